@@ design/bam_stream_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// BAM stream deframer assertion macros
// Shared concurrent check templates, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef BAM_STREAM_DEFRAMER_DEFINES_SVH
`define BAM_STREAM_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bam_stream_deframer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bam_stream_deframer: next-cycle check failed");

`endif

@@ design/bsd_pkg.sv @@
// ---------------------------------------------------------------------------
// BAM stream deframer package
// Parse phases, result kinds, segment codes and the segment entry function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsd_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_LTEXT = 4'd1,
        PH_TEXT  = 4'd2,
        PH_NREF  = 4'd3,
        PH_LNAME = 4'd4,
        PH_RNAME = 4'd5,
        PH_RLEN  = 4'd6,
        PH_FIXED = 4'd7,
        PH_NAME  = 4'd8,
        PH_CIGAR = 4'd9,
        PH_SEQ   = 4'd10,
        PH_QUAL  = 4'd11,
        PH_AUX   = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FIELDS  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } t_kind;

    localparam logic [2:0] SEG_TEXT  = 3'd0;
    localparam logic [2:0] SEG_NAME  = 3'd1;
    localparam logic [2:0] SEG_CIGAR = 3'd2;
    localparam logic [2:0] SEG_SEQ   = 3'd3;
    localparam logic [2:0] SEG_QUAL  = 3'd4;

    localparam int MAGIC_LEN   = 4;
    localparam int FIXED_LEN   = 36;
    // The record length word counts everything after itself: 32 bytes of fixed fields
    localparam int BLOCK_FIXED = 32;
    localparam int TDATA_W     = 240;
    localparam int TUSER_W     = 5;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] seg_left;
    } t_seg_sel;

    // Pick the first non-empty segment at or after start; aux if none is left.
    function automatic t_seg_sel enter_segment(
        input t_phase      start,
        input logic [7:0]  name_len,
        input logic [17:0] cigar_len,
        input logic [31:0] seq_pack,
        input logic [31:0] seq_len
    );
        t_seg_sel sel;
        sel.phase    = PH_AUX;
        sel.seg_left = '0;
        if (start <= PH_QUAL && seq_len != '0) begin
            sel.phase    = PH_QUAL;
            sel.seg_left = seq_len;
        end
        if (start <= PH_SEQ && seq_pack != '0) begin
            sel.phase    = PH_SEQ;
            sel.seg_left = seq_pack;
        end
        if (start <= PH_CIGAR && cigar_len != '0) begin
            sel.phase    = PH_CIGAR;
            sel.seg_left = {14'd0, cigar_len};
        end
        if (start <= PH_NAME && name_len != '0) begin
            sel.phase    = PH_NAME;
            sel.seg_left = {24'd0, name_len};
        end
        return sel;
    endfunction

endpackage

@@ design/bam_stream_deframer.sv @@
// ---------------------------------------------------------------------------
// BAM stream deframer
// Walks the BAM header, splits alignment records, emits decoded fixed fields
// and passes header text and record payload bytes through by segment.
// ---------------------------------------------------------------------------
// A byte's result is loaded into the output register as the byte is accepted.
// Throughput: one byte per cycle while results drain; parse state and the result
//   register both update in the accept cycle, so bytes stream with no gaps.
// Input ready drops only while a held result is not taken downstream.
// Reset (i_rst_n low, synchronous) returns the parser to the magic phase and
//   empties the result register; no memory, so no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bam_stream_deframer_defines.svh"

module bam_stream_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
    input  logic         s_axis_tuser,   // [0] end_mark
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] payload_byte, [39:8] ref_id, [71:40] position, [79:72] map_quality,
    // [95:80] bin_number, [111:96] flags, [143:112] mate_ref_id,
    // [175:144] mate_position, [207:176] template_length, [239:208] seq_length
    output logic [239:0] m_axis_tdata,
    output logic [4:0]   m_axis_tuser    // [1:0] kind, [4:2] segment
);

    // Parse state
    bsd_pkg::t_phase r_phase,      n_phase;
    logic [5:0]      r_byte_index, n_byte_index;  // magic and fixed-byte counter
    logic [31:0]     r_seg_left,   n_seg_left;
    logic [31:0]     r_refs_left,  n_refs_left;
    logic [31:0]     r_block_left, n_block_left;
    logic [1:0]      r_word_cnt,   n_word_cnt;    // bytes collected of a header word
    logic [23:0]     r_word,       n_word;        // lower three bytes, little endian
    logic [279:0]    r_rec,        n_rec;         // first 35 fixed bytes of a record

    // Lengths latched when a record's fixed part completes
    logic [7:0]      r_name_len,   n_name_len;
    logic [17:0]     r_cigar_len,  n_cigar_len;
    logic [31:0]     r_seq_pack,   n_seq_pack;
    logic [31:0]     r_seq_len,    n_seq_len;

    // Result register
    logic                        r_out_valid;
    logic [bsd_pkg::TDATA_W-1:0] r_out_tdata;
    logic [bsd_pkg::TUSER_W-1:0] r_out_tuser;

    logic              in_acc;
    logic              res_valid;
    bsd_pkg::t_kind    res_kind;
    logic [2:0]        res_seg;
    logic [7:0]        res_byte;
    logic [231:0]      res_fields;
    logic [31:0]       word;
    logic [287:0]      rec;
    logic [31:0]       blk_size;
    logic [32:0]       seq_round;
    bsd_pkg::t_seg_sel sel;
    logic              seg_phase;
    logic              body_phase;
    logic              text_take;
    logic              out_payload;

    // Take a new byte whenever the result register is empty or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign word = {s_axis_tdata, r_word};
    assign rec  = {s_axis_tdata, r_rec};

    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_seg_left   = r_seg_left;
        n_refs_left  = r_refs_left;
        n_block_left = r_block_left;
        n_word_cnt   = r_word_cnt;
        n_word       = r_word;
        n_rec        = r_rec;
        n_name_len   = r_name_len;
        n_cigar_len  = r_cigar_len;
        n_seq_pack   = r_seq_pack;
        n_seq_len    = r_seq_len;
        res_valid    = 1'b0;
        res_kind     = bsd_pkg::KIND_FIELDS;
        res_seg      = bsd_pkg::SEG_TEXT;
        res_byte     = '0;
        res_fields   = '0;
        blk_size     = rec[31:0];
        seq_round    = {1'b0, rec[191:160]} + 33'd1;
        sel          = '{phase: bsd_pkg::PH_AUX, seg_left: '0};

        if (s_axis_tuser) begin
            // End of stream: clean only between records; restart either way.
            res_valid    = !(r_phase == bsd_pkg::PH_FIXED && r_byte_index == '0);
            res_kind     = bsd_pkg::KIND_TRUNC;
            n_phase      = bsd_pkg::PH_MAGIC;
            n_byte_index = '0;
            n_seg_left   = '0;
            n_refs_left  = '0;
            n_block_left = '0;
            n_word_cnt   = '0;
        end else begin
            unique case (r_phase) inside
                bsd_pkg::PH_MAGIC: begin
                    // Skip the magic bytes unchecked.
                    if (r_byte_index == 6'(bsd_pkg::MAGIC_LEN - 1)) begin
                        n_byte_index = '0;
                        n_phase      = bsd_pkg::PH_LTEXT;
                    end else begin
                        n_byte_index = r_byte_index + 6'd1;
                    end
                end
                bsd_pkg::PH_LTEXT, bsd_pkg::PH_NREF, bsd_pkg::PH_LNAME,
                bsd_pkg::PH_RLEN: begin
                    n_word     = {s_axis_tdata, r_word[23:8]};
                    n_word_cnt = r_word_cnt + 2'd1;
                    if (r_word_cnt == 2'd3) begin
                        unique case (r_phase) inside
                            bsd_pkg::PH_LTEXT: begin
                                if (word != '0) begin
                                    n_seg_left = word;
                                    n_phase    = bsd_pkg::PH_TEXT;
                                end else begin
                                    n_phase = bsd_pkg::PH_NREF;
                                end
                            end
                            bsd_pkg::PH_NREF: begin
                                n_refs_left = word;
                                if (word != '0) begin
                                    n_phase = bsd_pkg::PH_LNAME;
                                end else begin
                                    n_phase      = bsd_pkg::PH_FIXED;
                                    n_byte_index = '0;
                                end
                            end
                            bsd_pkg::PH_LNAME: begin
                                if (word != '0) begin
                                    n_seg_left = word;
                                    n_phase    = bsd_pkg::PH_RNAME;
                                end else begin
                                    n_phase = bsd_pkg::PH_RLEN;
                                end
                            end
                            default: begin
                                // Reference length word closes one reference.
                                n_refs_left = r_refs_left - 32'd1;
                                if (n_refs_left != '0) begin
                                    n_phase = bsd_pkg::PH_LNAME;
                                end else begin
                                    n_phase      = bsd_pkg::PH_FIXED;
                                    n_byte_index = '0;
                                end
                            end
                        endcase
                    end
                end
                bsd_pkg::PH_TEXT: begin
                    res_valid  = 1'b1;
                    res_kind   = bsd_pkg::KIND_PAYLOAD;
                    res_seg    = bsd_pkg::SEG_TEXT;
                    res_byte   = s_axis_tdata;
                    n_seg_left = r_seg_left - 32'd1;
                    if (r_seg_left == 32'd1) begin
                        n_phase = bsd_pkg::PH_NREF;
                    end
                end
                bsd_pkg::PH_RNAME: begin
                    // Drop reference names.
                    n_seg_left = r_seg_left - 32'd1;
                    if (r_seg_left == 32'd1) begin
                        n_phase = bsd_pkg::PH_RLEN;
                    end
                end
                bsd_pkg::PH_FIXED: begin
                    n_rec = {s_axis_tdata, r_rec[279:8]};
                    if (r_byte_index == 6'(bsd_pkg::FIXED_LEN - 1)) begin
                        // Last fixed byte: decode the record and emit its fields.
                        n_byte_index = '0;
                        n_block_left = (blk_size > 32'(bsd_pkg::BLOCK_FIXED))
                                     ? blk_size - 32'(bsd_pkg::BLOCK_FIXED) : '0;
                        n_name_len   = rec[103:96];
                        n_cigar_len  = {rec[143:128], 2'b00};
                        n_seq_len    = rec[191:160];
                        n_seq_pack   = seq_round[32:1];
                        res_valid    = 1'b1;
                        res_kind     = bsd_pkg::KIND_FIELDS;
                        res_fields   = {rec[191:160], rec[287:256], rec[255:224],
                                        rec[223:192], rec[159:144], rec[127:112],
                                        rec[111:104], rec[95:64], rec[63:32]};
                        if (n_block_left != '0) begin
                            sel        = bsd_pkg::enter_segment(bsd_pkg::PH_NAME,
                                             n_name_len, n_cigar_len, n_seq_pack,
                                             n_seq_len);
                            n_phase    = sel.phase;
                            n_seg_left = sel.seg_left;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 6'd1;
                    end
                end
                bsd_pkg::PH_NAME, bsd_pkg::PH_CIGAR, bsd_pkg::PH_SEQ,
                bsd_pkg::PH_QUAL: begin
                    res_valid    = 1'b1;
                    res_kind     = bsd_pkg::KIND_PAYLOAD;
                    res_seg      = 3'(r_phase - bsd_pkg::PH_NAME + 4'd1);
                    res_byte     = s_axis_tdata;
                    n_seg_left   = r_seg_left - 32'd1;
                    n_block_left = r_block_left - 32'd1;
                    if (r_block_left == 32'd1) begin
                        // Block ends here, cutting the segment short if needed.
                        n_phase      = bsd_pkg::PH_FIXED;
                        n_byte_index = '0;
                    end else if (r_seg_left == 32'd1) begin
                        sel        = bsd_pkg::enter_segment(
                                         bsd_pkg::t_phase'(r_phase + 4'd1),
                                         r_name_len, r_cigar_len, r_seq_pack,
                                         r_seq_len);
                        n_phase    = sel.phase;
                        n_seg_left = sel.seg_left;
                    end
                end
                bsd_pkg::PH_AUX: begin
                    // Drop auxiliary bytes to the end of the block.
                    n_block_left = r_block_left - 32'd1;
                    if (r_block_left == 32'd1) begin
                        n_phase      = bsd_pkg::PH_FIXED;
                        n_byte_index = '0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Parse state: advance on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bsd_pkg::PH_MAGIC;
            r_byte_index <= '0;
            r_seg_left   <= '0;
            r_refs_left  <= '0;
            r_block_left <= '0;
            r_word_cnt   <= '0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_seg_left   <= n_seg_left;
            r_refs_left  <= n_refs_left;
            r_block_left <= n_block_left;
            r_word_cnt   <= n_word_cnt;
        end
    end

    // Collected bytes and latched lengths carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word      <= n_word;
            r_rec       <= n_rec;
            r_name_len  <= n_name_len;
            r_cigar_len <= n_cigar_len;
            r_seq_pack  <= n_seq_pack;
            r_seq_len   <= n_seq_len;
        end
    end

    // Result register: load on a producing transaction, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out_tdata <= {res_fields, res_byte};
            r_out_tuser <= {res_seg, res_kind};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // Checks
    assign seg_phase  = (r_phase == bsd_pkg::PH_TEXT) || (r_phase == bsd_pkg::PH_RNAME)
                     || (r_phase == bsd_pkg::PH_NAME) || (r_phase == bsd_pkg::PH_CIGAR)
                     || (r_phase == bsd_pkg::PH_SEQ)  || (r_phase == bsd_pkg::PH_QUAL);
    assign body_phase = (r_phase == bsd_pkg::PH_NAME) || (r_phase == bsd_pkg::PH_CIGAR)
                     || (r_phase == bsd_pkg::PH_SEQ)  || (r_phase == bsd_pkg::PH_QUAL)
                     || (r_phase == bsd_pkg::PH_AUX);
    assign text_take   = in_acc && !s_axis_tuser && (r_phase == bsd_pkg::PH_TEXT);
    assign out_payload = r_out_valid && (r_out_tuser[1:0] == bsd_pkg::KIND_PAYLOAD);

    `BSD_ASSERT_SAME(a_seg_left_live, seg_phase, r_seg_left != '0)
    `BSD_ASSERT_SAME(a_block_left_live, body_phase, r_block_left != '0)
    `BSD_ASSERT_SAME(a_fixed_index, r_phase == bsd_pkg::PH_FIXED, r_byte_index < 6'd36)
    `BSD_ASSERT_NEXT(a_end_restart, in_acc && s_axis_tuser, r_phase == bsd_pkg::PH_MAGIC)
    `BSD_ASSERT_NEXT(a_text_emits, text_take, out_payload)

endmodule

@@ verif/bam_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// BAM deframer result checker
// Follows every accepted input byte with its own parser of the BAM layout,
// queues the result each byte should cause and compares each accepted
// output transaction, field by field, against the oldest queued result.
// ---------------------------------------------------------------------------

module bam_result_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [7:0]   i_in_byte,
    input  logic         i_in_end,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [239:0] i_out_data,
    input  logic [4:0]   i_out_user,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_fields_seen,
    output int           o_payload_seen,
    output int           o_trunc_seen
);

    typedef struct packed {
        bsd_pkg::t_kind     kind;
        logic [2:0]         segment;
        logic [7:0]         payload;
        logic signed [31:0] ref_id;
        logic signed [31:0] position;
        logic [7:0]         map_quality;
        logic [15:0]        bin_number;
        logic [15:0]        flags;
        logic signed [31:0] mate_ref_id;
        logic signed [31:0] mate_position;
        logic signed [31:0] template_length;
        logic [31:0]        seq_length;
    } t_bam_result;

    t_bam_result pending_results[$];

    // parser state
    bsd_pkg::t_phase parse_phase;
    logic [31:0]     byte_count;
    logic [31:0]     seg_left;
    logic [31:0]     refs_left;
    logic [31:0]     block_left;
    logic [7:0]      name_len;
    logic [15:0]     cigar_n;
    logic [31:0]     word_shift;
    logic [63:0]     word_acc;
    logic [7:0]      fixed_buf [bsd_pkg::FIXED_LEN];
    logic [31:0]     read_len;

    function automatic void clear_parser();
        parse_phase = bsd_pkg::PH_MAGIC;
        byte_count  = '0;
        seg_left    = '0;
        refs_left   = '0;
        block_left  = '0;
        name_len    = '0;
        cigar_n     = '0;
        word_shift  = '0;
        word_acc    = '0;
        read_len    = '0;
        for (int i = 0; i < bsd_pkg::FIXED_LEN; i++) begin
            fixed_buf[i] = 8'h00;
        end
    endfunction

    function automatic void start_records();
        parse_phase = bsd_pkg::PH_FIXED;
        byte_count  = '0;
    endfunction

    function automatic logic [31:0] word_at(int idx);
        return {fixed_buf[idx + 3], fixed_buf[idx + 2], fixed_buf[idx + 1], fixed_buf[idx]};
    endfunction

    function automatic logic [31:0] section_length(bsd_pkg::t_phase ph);
        case (ph)
            bsd_pkg::PH_NAME:  return {24'd0, name_len};
            bsd_pkg::PH_CIGAR: return {14'd0, cigar_n, 2'b00};
            // packed bases: round up without wrapping at the top of the range
            bsd_pkg::PH_SEQ:   return 32'(({1'b0, read_len} + 33'd1) >> 1);
            bsd_pkg::PH_QUAL:  return read_len;
            default:           return 32'd0;
        endcase
    endfunction

    // Skip empty sections; fall into aux when none is left.
    function automatic void open_section(bsd_pkg::t_phase start);
        logic [31:0] len;
        bit          found;
        found       = 1'b0;
        parse_phase = bsd_pkg::PH_AUX;
        seg_left    = '0;
        for (int p = int'(start); p <= int'(bsd_pkg::PH_QUAL); p++) begin
            if (!found) begin
                len = section_length(bsd_pkg::t_phase'(p));
                if (len != 0) begin
                    parse_phase = bsd_pkg::t_phase'(p);
                    seg_left    = len;
                    found       = 1'b1;
                end
            end
        end
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic end_flag);
        t_bam_result res;
        logic [31:0] w;
        logic [31:0] bsize;
        bit          clean;
        res = '0;
        if (end_flag) begin
            clean = (parse_phase == bsd_pkg::PH_FIXED && byte_count == 0);
            clear_parser();
            if (!clean) begin
                res.kind = bsd_pkg::KIND_TRUNC;
                pending_results.push_back(res);
            end
        end else begin
            case (parse_phase) inside
                bsd_pkg::PH_MAGIC: begin
                    byte_count++;
                    if (byte_count >= bsd_pkg::MAGIC_LEN) begin
                        byte_count  = '0;
                        parse_phase = bsd_pkg::PH_LTEXT;
                    end
                end
                bsd_pkg::PH_LTEXT, bsd_pkg::PH_NREF, bsd_pkg::PH_LNAME,
                bsd_pkg::PH_RLEN: begin
                    word_acc   |= 64'(b) << word_shift[4:0];
                    word_shift += 8;
                    if (word_shift >= 32) begin
                        w          = word_acc[31:0];
                        word_acc   = '0;
                        word_shift = '0;
                        case (parse_phase)
                            bsd_pkg::PH_LTEXT: begin
                                if (w != 0) begin
                                    seg_left    = w;
                                    parse_phase = bsd_pkg::PH_TEXT;
                                end else begin
                                    parse_phase = bsd_pkg::PH_NREF;
                                end
                            end
                            bsd_pkg::PH_NREF: begin
                                refs_left = w;
                                if (w != 0) parse_phase = bsd_pkg::PH_LNAME;
                                else start_records();
                            end
                            bsd_pkg::PH_LNAME: begin
                                if (w != 0) begin
                                    seg_left    = w;
                                    parse_phase = bsd_pkg::PH_RNAME;
                                end else begin
                                    parse_phase = bsd_pkg::PH_RLEN;
                                end
                            end
                            default: begin
                                refs_left--;
                                if (refs_left != 0) parse_phase = bsd_pkg::PH_LNAME;
                                else start_records();
                            end
                        endcase
                    end
                end
                bsd_pkg::PH_TEXT: begin
                    res.kind    = bsd_pkg::KIND_PAYLOAD;
                    res.segment = bsd_pkg::SEG_TEXT;
                    res.payload = b;
                    pending_results.push_back(res);
                    seg_left--;
                    if (seg_left == 0) parse_phase = bsd_pkg::PH_NREF;
                end
                bsd_pkg::PH_RNAME: begin
                    seg_left--;
                    if (seg_left == 0) parse_phase = bsd_pkg::PH_RLEN;
                end
                bsd_pkg::PH_FIXED: begin
                    fixed_buf[byte_count] = b;
                    byte_count++;
                    if (byte_count == bsd_pkg::FIXED_LEN) begin
                        byte_count = '0;
                        bsize      = word_at(0);
                        block_left = (bsize > bsd_pkg::BLOCK_FIXED)
                                   ? 32'(bsize - bsd_pkg::BLOCK_FIXED) : 32'd0;
                        name_len   = fixed_buf[12];
                        cigar_n    = {fixed_buf[17], fixed_buf[16]};
                        read_len   = word_at(20);
                        res.kind            = bsd_pkg::KIND_FIELDS;
                        res.ref_id          = word_at(4);
                        res.position        = word_at(8);
                        res.map_quality     = fixed_buf[13];
                        res.bin_number      = {fixed_buf[15], fixed_buf[14]};
                        res.flags           = {fixed_buf[19], fixed_buf[18]};
                        res.mate_ref_id     = word_at(24);
                        res.mate_position   = word_at(28);
                        res.template_length = word_at(32);
                        res.seq_length      = read_len;
                        pending_results.push_back(res);
                        if (block_left != 0) open_section(bsd_pkg::PH_NAME);
                    end
                end
                bsd_pkg::PH_NAME, bsd_pkg::PH_CIGAR, bsd_pkg::PH_SEQ,
                bsd_pkg::PH_QUAL: begin
                    res.kind    = bsd_pkg::KIND_PAYLOAD;
                    res.segment = bsd_pkg::SEG_NAME + 3'(parse_phase - bsd_pkg::PH_NAME);
                    res.payload = b;
                    pending_results.push_back(res);
                    seg_left--;
                    block_left--;
                    if (block_left == 0) start_records();
                    else if (seg_left == 0)
                        open_section(bsd_pkg::t_phase'(parse_phase + 4'd1));
                end
                bsd_pkg::PH_AUX: begin
                    block_left--;
                    if (block_left == 0) start_records();
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_result(input t_bam_result got);
        t_bam_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result kind %0d byte %0h arrived with nothing expected",
                     $time, got.kind, got.payload);
            o_fail_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("segment", 32'(want.segment), 32'(got.segment));
            check_field("payload_byte", 32'(want.payload), 32'(got.payload));
            check_field("ref_id", want.ref_id, got.ref_id);
            check_field("position", want.position, got.position);
            check_field("map_quality", 32'(want.map_quality), 32'(got.map_quality));
            check_field("bin_number", 32'(want.bin_number), 32'(got.bin_number));
            check_field("flags", 32'(want.flags), 32'(got.flags));
            check_field("mate_ref_id", want.mate_ref_id, got.mate_ref_id);
            check_field("mate_position", want.mate_position, got.mate_position);
            check_field("template_length", want.template_length, got.template_length);
            check_field("seq_length", want.seq_length, got.seq_length);
            case (want.kind)
                bsd_pkg::KIND_FIELDS:  o_fields_seen++;
                bsd_pkg::KIND_PAYLOAD: o_payload_seen++;
                default:               o_trunc_seen++;
            endcase
        end
    endtask

    function automatic t_bam_result unpack_result(logic [239:0] data, logic [4:0] user);
        t_bam_result r;
        r.kind            = bsd_pkg::t_kind'(user[1:0]);
        r.segment         = user[4:2];
        r.payload         = data[7:0];
        r.ref_id          = data[39:8];
        r.position        = data[71:40];
        r.map_quality     = data[79:72];
        r.bin_number      = data[95:80];
        r.flags           = data[111:96];
        r.mate_ref_id     = data[143:112];
        r.mate_position   = data[175:144];
        r.template_length = data[207:176];
        r.seq_length      = data[239:208];
        return r;
    endfunction

    // Predict before comparing so a same-cycle result would still line up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_results.delete();
            o_fail_count   = 0;
            o_fields_seen  = 0;
            o_payload_seen = 0;
            o_trunc_seen   = 0;
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_in_byte, i_in_end);
            if (i_out_valid && i_out_ready) compare_result(unpack_result(i_out_data, i_out_user));
        end
        o_pending = pending_results.size();
    end

endmodule

@@ verif/tb_bam_stream_deframer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// BAM stream deframer testbench
// Feeds generated BAM streams (well-formed, cut short, and noise) one byte
// per transaction with bursty input and a stalling output side; a checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------

module tb_bam_stream_deframer;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1100;
    localparam int MAX_GAP      = 12;   // longest sender pause, cycles
    localparam int DRAIN_CYCLES = 16;   // quiet time after the last result
    localparam int IDLE_LIMIT   = 4000; // cycles without any transaction

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;  // [7:0] stream_byte
    logic         s_axis_tuser  = 1'b0;   // [0] end_mark
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [7:0] payload_byte, [39:8] ref_id, [71:40] position, [79:72] map_quality,
    // [95:80] bin_number, [111:96] flags, [143:112] mate_ref_id,
    // [175:144] mate_position, [207:176] template_length, [239:208] seq_length
    logic [239:0] m_axis_tdata;
    logic [4:0]   m_axis_tuser;           // [1:0] kind, [4:2] segment

    int fail_count;
    int pending;
    int fields_seen;
    int payload_seen;
    int trunc_seen;

    // stream under construction: bit 8 marks the end-of-stream transaction
    logic [8:0]  stream_q[$];
    bit          stream_cut;
    int unsigned stream_cap;
    int          burst_left   = 0;
    int          items_sent   = 0;
    int          streams_sent = 0;
    int          streams_cut  = 0;
    bit          mid_pause_done = 1'b0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_span = 0;
    int          stall_hold = 0;
    int          stall_tick = 0;
    int          idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    bam_stream_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bam_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_end       (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_out_user     (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_fields_seen  (fields_seen),
        .o_payload_seen (payload_seen),
        .o_trunc_seen   (trunc_seen)
    );

    // Output side: switch between randomly chosen stall patterns over random spans so
    // back-pressure lands on every parse phase, with clean stretches too.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_span = $urandom_range(16, 160);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     m_axis_tready = 1'b1;
            STALL_RANDOM:   m_axis_tready = ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: m_axis_tready = (stall_tick % 3 != 0);
            default: begin
                // long runs of ready and not-ready
                if (stall_hold == 0) begin
                    m_axis_tready = ~m_axis_tready;
                    stall_hold    = $urandom_range(1, 24);
                end else begin
                    stall_hold--;
                end
            end
        endcase
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_bam_stream_deframer NOT OK");
                $finish;
            end
        end
    end

    // ---------------- stream construction ----------------

    function automatic void start_stream();
        stream_q.delete();
        stream_cut = 1'b0;
        stream_cap = 32'hFFFF_FFFF;
    endfunction

    // Drop every byte past the cap; once cut, the stream takes no more bytes.
    function automatic void push_byte(input logic [7:0] b);
        if (stream_q.size() >= stream_cap) stream_cut = 1'b1;
        if (!stream_cut) stream_q.push_back({1'b0, b});
    endfunction

    function automatic void push_half(input logic [15:0] v);
        push_byte(v[7:0]);
        push_byte(v[15:8]);
    endfunction

    function automatic void push_word(input logic [31:0] v);
        push_half(v[15:0]);
        push_half(v[31:16]);
    endfunction

    // The data byte of the end transaction is ignored; randomize it anyway.
    function automatic void push_end();
        stream_q.push_back({1'b1, 8'($urandom)});
    endfunction

    // Cap the stream a few bytes ahead; used before any length too large to send.
    function automatic void cut_soon();
        int unsigned limit;
        limit = stream_q.size() + $urandom_range(0, 16);
        if (limit < stream_cap) stream_cap = limit;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return ($urandom_range(0, 7) == 0) ? 8'(rand_word()) : 8'($urandom);
    endfunction

    function automatic logic [31:0] huge_length();
        case ($urandom_range(0, 2))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom | 32'h0001_0000;
        endcase
    endfunction

    // Mostly small lengths; now and then one that forces the stream to end early.
    function automatic logic [31:0] pick_length(input int small_max);
        if ($urandom_range(0, 19) == 0) begin
            cut_soon();
            return huge_length();
        end
        return $urandom_range(0, small_max);
    endfunction

    // Bytes a well-formed record carries after its length word, aux excluded.
    function automatic logic [31:0] BLOCK_FIXED_LEN(input logic [7:0] nl, input logic [15:0] nc,
                                                    input logic [31:0] ls);
        return 32 + nl + 4 * nc + (ls + 1) / 2 + ls;
    endfunction

    function automatic void add_record();
        logic [7:0]  nl;
        logic [15:0] nc;
        logic [31:0] ls;
        logic [31:0] bs;
        logic [31:0] body;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // wild sizes: any name length, cigar count and read length,
            // with a block short enough to cut the sections off
            nl = rand_byte();
            nc = 16'(rand_word());
            ls = rand_word();
            bs = $urandom_range(0, 90);
        end else begin
            nl = 8'($urandom_range(0, 5));
            nc = 16'($urandom_range(0, 2));
            ls = $urandom_range(0, 7);
            bs = BLOCK_FIXED_LEN(nl, nc, ls) + $urandom_range(0, 3);
            if (pick < 27) begin
                bs = $urandom_range(0, bs);  // short block, maybe below the fixed part
            end else if (pick < 29) begin
                cut_soon();
                bs = huge_length();
            end
        end
        push_word(bs);
        push_word(rand_word());   // ref_id
        push_word(rand_word());   // pos
        push_byte(nl);
        push_byte(rand_byte());   // mapq
        push_half(16'(rand_word()));  // bin
        push_half(nc);
        push_half(16'(rand_word()));  // flag
        push_word(ls);
        push_word(rand_word());   // next ref_id
        push_word(rand_word());   // next pos
        push_word(rand_word());   // tlen
        body = (bs > 32) ? bs - 32 : 32'd0;
        for (int unsigned i = 0; i < body && !stream_cut; i++) begin
            push_byte(rand_byte());
        end
    endfunction

    function automatic void build_stream();
        int unsigned pick;
        logic [31:0] len;
        logic [31:0] n_ref;
        int          n_rec;
        start_stream();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // noise: whatever the parser makes of random bytes
            repeat ($urandom_range(0, 40)) push_byte(8'($urandom));
        end else begin
            if (pick < 35) stream_cap = $urandom_range(0, 90);
            repeat (4) push_byte(rand_byte());  // magic, never checked
            len = pick_length(6);
            push_word(len);
            for (int unsigned i = 0; i < len && !stream_cut; i++) push_byte(rand_byte());
            n_ref = pick_length(2);
            push_word(n_ref);
            for (int unsigned r = 0; r < n_ref && !stream_cut; r++) begin
                len = pick_length(3);
                push_word(len);
                for (int unsigned i = 0; i < len && !stream_cut; i++) push_byte(rand_byte());
                push_word(rand_word());  // l_ref
            end
            n_rec = $urandom_range(0, 3);
            for (int k = 0; k < n_rec && !stream_cut; k++) add_record();
        end
        if (stream_cut) streams_cut++;
        push_end();
    endfunction

    // ---------------- driving ----------------

    // Enter at a falling edge; leave at the falling edge after acceptance
    // with tvalid still high, so back-to-back bytes go out with no gap in tvalid.
    task automatic send_item(input logic [8:0] item);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = item[7:0];
        s_axis_tuser  = item[8];
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int k = 0; k < stream_q.size(); k++) send_item(stream_q[k]);
        streams_sent++;
    endtask

    // Hold the sender until every queued result has come out.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty stream: an end mark right after reset is a truncation.
        start_stream();
        push_end();
        send_stream();
        // End inside the magic bytes, with both extreme byte values.
        start_stream();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_end();
        send_stream();
        // Bare header with no text and no references, then a clean end.
        start_stream();
        push_word(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(32'h0000_0000);
        push_end();
        send_stream();
        drain_results();

        // Random streams until the item budget is spent.
        while (items_sent < ITEM_TARGET) begin
            if (!mid_pause_done && items_sent >= ITEM_TARGET / 2) begin
                drain_results();
                mid_pause_done = 1'b1;
            end
            build_stream();
            send_stream();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d bytes and end marks in %0d streams, %0d of them cut short",
                 items_sent, streams_sent, streams_cut);
        $display("matched %0d record headers, %0d payload bytes, %0d truncation flags",
                 fields_seen, payload_seen, trunc_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_bam_stream_deframer OK");
        end else begin
            $display("tb_bam_stream_deframer NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/bsd_pkg.sv
design/bam_stream_deframer.sv
verif/bam_result_checker.sv
verif/tb_bam_stream_deframer.sv
